// ===== hdl/gbfs_pkg.sv =====
// Shared types and constants for the grid breadth-first search block.
// No dependencies.
package gbfs_pkg;
   localparam int MaxCols = 64;
   localparam int MaxRows = 64;
   localparam int ColW = $clog2(MaxCols);
   localparam int RowW = $clog2(MaxRows);
   localparam int CellW = ColW + RowW;
   localparam int Cells = MaxCols * MaxRows;
   localparam int CntW = CellW + 1;

   typedef enum logic [1:0] {
      MARK_NONE = 2'd0, MARK_START = 2'd1, MARK_DISC = 2'd2, MARK_GOAL = 2'd3
   } mark_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0, ST_NOT_FOUND = 2'd1, ST_RANGE = 2'd2, ST_READ = 2'd3
   } status_type;

   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;
   localparam logic CMD_SEARCH = 1'b0;
   localparam logic CMD_READ = 1'b1;
endpackage

// ===== hdl/grid_breadth_first_search.sv =====
// Top level of the grid breadth-first search: sequencer, neighbor stepper,
// clearing pass. Uses gbfs_pkg, gbfs_mark_ram, gbfs_queue_ram.
//
// Usage: write grid_width (index 0) and grid_height (index 1) on the csr_
// channel; csr_ready is always high. Pulse start with the req_ fields when
// busy is low. One response follows with rsp_valid high for one cycle; the
// receiver cannot stall it.
// After reset a clearing pass walks the 4096-entry mark map, one entry a
// cycle; busy stays high throughout the pass.
// A rejected request goes from S_IDLE through S_DONE to the response; a read
// passes S_READ between them. A search, for each dequeued cell, fetches it
// (S_DEQ, S_DEQ_WAIT) and compares it with the goal (S_CHECK), then steps
// through the nine neighbor codes in S_NB_READ and, per in-grid neighbor,
// reads its mark (S_NB_WAIT), then tests and marks it (S_NB_TEST); the
// neighbors are handled one at a time. busy is high for the whole search.
module grid_breadth_first_search (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [5:0] req_start_col,
   input  logic [5:0] req_start_row,
   input  logic [5:0] req_goal_col,
   input  logic [5:0] req_goal_row,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_cell_mark,
   output logic [12:0] rsp_cells_dequeued,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);
   import gbfs_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_DEQ, S_DEQ_WAIT, S_CHECK, S_NB_READ,
      S_NB_WAIT, S_NB_TEST, S_DONE
   } state_type;

   state_type        state_ff;
   logic [6:0]       width_ff, height_ff;
   logic [CellW-1:0] clr_ff;
   logic [ColW-1:0]  gc_ff, cc_ff;
   logic [RowW-1:0]  gr_ff, cr_ff;
   logic [CellW-1:0] head_ff;
   logic [CntW-1:0]  tail_ff, count_ff;
   logic [3:0]       nb_ff;
   logic [ColW-1:0]  nc_ff;
   logic [RowW-1:0]  nr_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff, rsp_mark_ff;
   logic [12:0]      rsp_cnt_ff;

   logic             m_we;
   logic [CellW-1:0] m_waddr, m_raddr;
   logic [1:0]       m_wdata, m_rdata;
   logic             q_we;
   logic [CellW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

   gbfs_mark_ram u_mark (.clock, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata));
   gbfs_queue_ram u_queue (.clock, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));

   // effective dimensions, saturated at the maximum
   logic [6:0] w_eff, h_eff;
   assign w_eff = (width_ff > 7'(MaxCols)) ? 7'(MaxCols) : width_ff;
   assign h_eff = (height_ff > 7'(MaxRows)) ? 7'(MaxRows) : height_ff;

   logic s_ok, g_ok;
   assign s_ok = ({1'b0, req_start_col} < w_eff) && ({1'b0, req_start_row} < h_eff);
   assign g_ok = ({1'b0, req_goal_col} < w_eff) && ({1'b0, req_goal_row} < h_eff);

   // neighbor offset from step code 0..8 (4 is the center), row-major order
   logic [ColW:0] nc_calc;
   logic [RowW:0] nr_calc;
   logic [1:0]    nb_dr, nb_dc;
   always_comb begin
      case (nb_ff)
         4'd0: begin nb_dr = 2'd0; nb_dc = 2'd0; end
         4'd1: begin nb_dr = 2'd0; nb_dc = 2'd1; end
         4'd2: begin nb_dr = 2'd0; nb_dc = 2'd2; end
         4'd3: begin nb_dr = 2'd1; nb_dc = 2'd0; end
         4'd5: begin nb_dr = 2'd1; nb_dc = 2'd2; end
         4'd6: begin nb_dr = 2'd2; nb_dc = 2'd0; end
         4'd7: begin nb_dr = 2'd2; nb_dc = 2'd1; end
         4'd8: begin nb_dr = 2'd2; nb_dc = 2'd2; end
         default: begin nb_dr = 2'd1; nb_dc = 2'd1; end
      endcase
      nr_calc = {1'b0, cr_ff} + (RowW+1)'(nb_dr) - (RowW+1)'(1);
      nc_calc = {1'b0, cc_ff} + (ColW+1)'(nb_dc) - (ColW+1)'(1);
   end
   logic nb_in;
   assign nb_in = (nb_ff != 4'd4) && !nr_calc[RowW] && !nc_calc[ColW]
      && (7'(nr_calc) < h_eff) && (7'(nc_calc) < w_eff);

   logic [CellW-1:0] nb_cell, cur_cell, goal_cell, start_cell;
   assign nb_cell = {nr_ff, nc_ff};
   assign cur_cell = {cr_ff, cc_ff};
   assign goal_cell = {gr_ff, gc_ff};
   assign start_cell = {req_start_row, req_start_col};

   // memory port control
   always_comb begin
      m_we = 1'b0; m_waddr = nb_cell; m_wdata = MARK_DISC;
      m_raddr = nb_cell;
      q_we = 1'b0; q_waddr = tail_ff[CellW-1:0]; q_wdata = nb_cell;
      q_raddr = head_ff;
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_waddr = clr_ff; m_wdata = MARK_NONE;
         end
         S_IDLE: begin
            m_raddr = start_cell;
            if (start && req_cmd == CMD_SEARCH && s_ok && g_ok) begin
               m_we = 1'b1; m_waddr = start_cell; m_wdata = MARK_START;
               q_we = 1'b1; q_waddr = '0; q_wdata = start_cell;
            end
         end
         S_CHECK: begin
            if (cur_cell == goal_cell) begin
               m_we = 1'b1; m_waddr = cur_cell; m_wdata = MARK_GOAL;
            end
         end
         S_NB_TEST: begin
            if (m_rdata == MARK_NONE) begin
               m_we = 1'b1;
               q_we = !tail_ff[CellW];
            end
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         width_ff <= 7'd16;
         height_ff <= 7'd16;
         rsp_valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            if (csr_index == CSR_WIDTH) width_ff <= csr_data;
            else height_ff <= csr_data;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CellW'(Cells - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  rsp_mark_ff <= MARK_NONE;
                  rsp_cnt_ff <= '0;
                  gc_ff <= req_goal_col; gr_ff <= req_goal_row;
                  if (!s_ok || (req_cmd == CMD_SEARCH && !g_ok)) begin
                     rsp_status_ff <= ST_RANGE;
                     state_ff <= S_DONE;
                  end else if (req_cmd == CMD_READ) begin
                     rsp_status_ff <= ST_READ;
                     state_ff <= S_READ;
                  end else begin
                     rsp_status_ff <= ST_NOT_FOUND;
                     head_ff <= '0;
                     tail_ff <= CntW'(1);
                     count_ff <= '0;
                     state_ff <= S_DEQ;
                  end
               end
            end
            S_READ: begin
               rsp_mark_ff <= m_rdata;
               state_ff <= S_DONE;
            end
            S_DEQ: begin
               if ({1'b0, head_ff} == tail_ff || (head_ff == '0 && count_ff != '0)) begin
                  rsp_cnt_ff <= 13'(count_ff);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DEQ_WAIT;
               end
            end
            S_DEQ_WAIT: begin
               cr_ff <= q_rdata[CellW-1:ColW];
               cc_ff <= q_rdata[ColW-1:0];
               head_ff <= head_ff + 1'b1;
               count_ff <= count_ff + 1'b1;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               nb_ff <= '0;
               if (cur_cell == goal_cell) begin
                  rsp_status_ff <= ST_FOUND;
                  rsp_cnt_ff <= 13'(count_ff);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_NB_READ;
               end
            end
            S_NB_READ: begin
               if (nb_ff == 4'd9) begin
                  state_ff <= S_DEQ;
               end else begin
                  nr_ff <= nr_calc[RowW-1:0];
                  nc_ff <= nc_calc[ColW-1:0];
                  nb_ff <= nb_ff + 1'b1;
                  if (nb_in) state_ff <= S_NB_WAIT;
               end
            end
            S_NB_WAIT: state_ff <= S_NB_TEST;
            S_NB_TEST: begin
               if (m_rdata == MARK_NONE && !tail_ff[CellW]) tail_ff <= tail_ff + 1'b1;
               state_ff <= S_NB_READ;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cell_mark = rsp_mark_ff;
   assign rsp_cells_dequeued = rsp_cnt_ff;
endmodule

// ===== hdl/gbfs_mark_ram.sv =====
// Mark map memory: one 2-bit mark per cell, registered read.
// Uses gbfs_pkg.
module gbfs_mark_ram (
   input  logic                      clock,
   input  logic                      we,
   input  logic [gbfs_pkg::CellW-1:0] waddr,
   input  logic [1:0]                wdata,
   input  logic [gbfs_pkg::CellW-1:0] raddr,
   output logic [1:0]                rdata
);
   import gbfs_pkg::*;
   logic [1:0] mem [Cells];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ===== hdl/gbfs_queue_ram.sv =====
// Frontier queue memory: cell indices, registered read.
// Uses gbfs_pkg.
module gbfs_queue_ram (
   input  logic                      clock,
   input  logic                      we,
   input  logic [gbfs_pkg::CellW-1:0] waddr,
   input  logic [gbfs_pkg::CellW-1:0] wdata,
   input  logic [gbfs_pkg::CellW-1:0] raddr,
   output logic [gbfs_pkg::CellW-1:0] rdata
);
   import gbfs_pkg::*;
   logic [CellW-1:0] mem [Cells];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ===== sim/tb_grid_breadth_first_search.sv =====
// Self-checking testbench for grid_breadth_first_search: random and directed
// searches and mark reads over several grid sizes, checked against a BFS predictor.
// Depends on gbfs_pkg and the grid_breadth_first_search RTL.
module tb_grid_breadth_first_search;
   import gbfs_pkg::*;

   typedef enum {K_REQ, K_CFG, K_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic       cmd;
      logic [5:0] sc, sr, gc, gr;
      logic       idx;
      logic [6:0] data;
   } step_item_type;

   typedef struct {
      status_type  status;
      mark_type    mark;
      logic [12:0] count;
   } search_result_type;

   localparam int IdleLimit = 1000000;

   logic        clock, reset, start, busy;
   logic        req_cmd;
   logic [5:0]  req_start_col, req_start_row, req_goal_col, req_goal_row;
   logic        rsp_valid;
   logic [1:0]  rsp_status, rsp_cell_mark;
   logic [12:0] rsp_cells_dequeued;
   logic        csr_valid, csr_ready, csr_index;
   logic [6:0]  csr_data;

   grid_breadth_first_search uut (.*);

   // predictor state
   mark_type          marks [Cells];
   int                frontier [Cells];
   logic [6:0]        cur_width = 7'd16, cur_height = 7'd16;
   step_item_type     pending [$];
   search_result_type expected [$];
   int                fails = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int eff_dim(logic [6:0] v, int maxv);
      return (v > maxv) ? maxv : int'(v);
   endfunction

   // BFS prediction for one accepted request
   function automatic search_result_type predict_search(step_item_type it);
      search_result_type res;
      int w, h, head, tail, cur, goal, r, c, nr, nc, n;
      w = eff_dim(cur_width, MaxCols);
      h = eff_dim(cur_height, MaxRows);
      res.status = ST_NOT_FOUND;
      res.mark = MARK_NONE;
      res.count = '0;
      if (it.cmd == CMD_READ) begin
         if (it.sc >= w || it.sr >= h) res.status = ST_RANGE;
         else begin
            res.status = ST_READ;
            res.mark = marks[it.sr * MaxCols + it.sc];
         end
         return res;
      end
      if (it.sc >= w || it.sr >= h || it.gc >= w || it.gr >= h) begin
         res.status = ST_RANGE;
         return res;
      end
      goal = it.gr * MaxCols + it.gc;
      cur = it.sr * MaxCols + it.sc;
      marks[cur] = MARK_START;
      frontier[0] = cur;
      head = 0;
      tail = 1;
      while (head < tail) begin
         cur = frontier[head];
         head++;
         res.count++;
         if (cur == goal) begin
            marks[cur] = MARK_GOAL;
            res.status = ST_FOUND;
            break;
         end
         r = cur / MaxCols;
         c = cur % MaxCols;
         // neighbors in ascending cell index
         for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++) begin
               nr = r + dr;
               nc = c + dc;
               if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
               n = nr * MaxCols + nc;
               if (marks[n] == MARK_NONE) begin
                  marks[n] = MARK_DISC;
                  if (tail < Cells) begin
                     frontier[tail] = n;
                     tail++;
                  end
               end
            end
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
      fails++;
   endtask

   function automatic void add_req(logic cmd, int sc, int sr, int gc, int gr);
      step_item_type it;
      it.kind = K_REQ;
      it.cmd = cmd;
      it.sc = 6'(sc);
      it.sr = 6'(sr);
      it.gc = 6'(gc);
      it.gr = 6'(gr);
      it.idx = CSR_WIDTH;
      it.data = '0;
      pending = {pending, it};
   endfunction

   function automatic void add_grid(int w, int h);
      step_item_type it;
      it.kind = K_CFG;
      it.cmd = CMD_SEARCH;
      {it.sc, it.sr, it.gc, it.gr} = '0;
      it.idx = CSR_WIDTH;
      it.data = 7'(w);
      pending = {pending, it};
      it.idx = CSR_HEIGHT;
      it.data = 7'(h);
      pending = {pending, it};
   endfunction

   function automatic void add_drain();
      step_item_type it;
      it.kind = K_DRAIN;
      it.cmd = CMD_SEARCH;
      {it.sc, it.sr, it.gc, it.gr} = '0;
      it.idx = CSR_WIDTH;
      it.data = '0;
      pending = {pending, it};
   endfunction

   // mostly in-grid cells; some fully random fields to hit range checks and high bits
   function automatic void add_random(int w, int h);
      int ew, eh;
      logic cmd;
      ew = eff_dim(7'(w), MaxCols);
      eh = eff_dim(7'(h), MaxRows);
      cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_SEARCH;
      if (ew == 0 || eh == 0 || $urandom_range(0, 9) < 2)
         add_req(cmd, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      else
         add_req(cmd, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                 $urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
   endfunction

   // request and register driver
   int   gap = 0, settle = 0;
   logic n_start, n_csr;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         csr_index <= CSR_WIDTH;
         csr_data <= '0;
         req_cmd <= CMD_SEARCH;
         req_start_col <= '0;
         req_start_row <= '0;
         req_goal_col <= '0;
         req_goal_row <= '0;
         gap = 0;
      end else begin
         n_start = start;
         n_csr = csr_valid;
         if (start && !busy) begin
            step_item_type it;
            it.cmd = req_cmd;
            it.sc = req_start_col;
            it.sr = req_start_row;
            it.gc = req_goal_col;
            it.gr = req_goal_row;
            expected = {expected, predict_search(it)};
            n_start = 1'b0;
            gap = $urandom_range(0, 3);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) cur_width = csr_data;
            else cur_height = csr_data;
            n_csr = 1'b0;
            gap = $urandom_range(0, 3);
         end
         if (expected.size() != 0) settle = 4;
         else if (settle > 0) settle--;
         if (!n_start && !n_csr) begin
            if (gap > 0) gap--;
            else if (pending.size() != 0) begin
               if (pending[0].kind == K_REQ) begin
                  req_cmd <= pending[0].cmd;
                  req_start_col <= pending[0].sc;
                  req_start_row <= pending[0].sr;
                  req_goal_col <= pending[0].gc;
                  req_goal_row <= pending[0].gr;
                  n_start = 1'b1;
                  pending.delete(0);
               end else if (expected.size() == 0 && settle == 0 && !start) begin
                  if (pending[0].kind == K_CFG) begin
                     csr_index <= pending[0].idx;
                     csr_data <= pending[0].data;
                     n_csr = 1'b1;
                  end
                  pending.delete(0);
               end
            end
         end
         start <= n_start;
         csr_valid <= n_csr;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            fails++;
         end else begin
            search_result_type e;
            e = expected[0];
            expected.delete(0);
            if (rsp_status !== e.status)
               report_mismatch("status", int'(rsp_status), int'(e.status));
            if (rsp_cell_mark !== e.mark)
               report_mismatch("cell_mark", int'(rsp_cell_mark), int'(e.mark));
            if (rsp_cells_dequeued !== e.count)
               report_mismatch("cells_dequeued", int'(rsp_cells_dequeued), int'(e.count));
         end
      end
   end

   // watchdog on cycles without any handshake
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid)
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int w, h;
      reset = 1'b1;
      foreach (marks[i]) marks[i] = MARK_NONE;

      // directed part on the reset 16x16 grid
      add_req(CMD_READ, 0, 0, 0, 0);
      add_req(CMD_READ, 16, 0, 0, 0);
      add_req(CMD_READ, 0, 16, 0, 0);
      add_req(CMD_READ, 63, 63, 63, 63);
      add_req(CMD_SEARCH, 16, 0, 0, 0);
      add_req(CMD_SEARCH, 0, 16, 0, 0);
      add_req(CMD_SEARCH, 0, 0, 16, 0);
      add_req(CMD_SEARCH, 0, 0, 0, 63);
      add_req(CMD_SEARCH, 0, 0, 0, 0);          // start equals goal
      add_req(CMD_READ, 0, 0, 0, 0);
      add_req(CMD_SEARCH, 15, 15, 0, 15);
      add_req(CMD_READ, 14, 14, 0, 0);
      add_req(CMD_SEARCH, 15, 15, 3, 3);        // start already visited
      add_req(CMD_READ, 15, 15, 0, 0);
      add_drain();
      add_grid(1, 1);
      add_req(CMD_SEARCH, 0, 0, 0, 0);
      add_req(CMD_READ, 0, 0, 0, 0);
      add_req(CMD_READ, 1, 0, 0, 0);
      add_grid(0, 5);                           // empty grid
      add_req(CMD_READ, 0, 0, 0, 0);
      add_req(CMD_SEARCH, 0, 0, 0, 0);
      add_grid(127, 3);                         // width saturates
      add_req(CMD_SEARCH, 0, 0, 63, 2);
      add_req(CMD_READ, 63, 2, 0, 0);
      add_req(CMD_SEARCH, 5, 1, 20, 0);

      // random phases on small grids
      for (int p = 0; p < 9; p++) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 12);
         add_grid(w, h);
         for (int i = 0; i < 9; i++) begin
            add_random(w, h);
            if (i == 4 && p % 3 == 0) add_drain();
         end
      end
      // full-size grid, few items
      add_grid(64, 127);
      add_req(CMD_SEARCH, 63, 63, 0, 0);
      add_req(CMD_READ, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) add_random(64, 64);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending.size() != 0 || expected.size() != 0 || start || csr_valid);
      repeat (20) @(posedge clock);
      if (fails == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/gbfs_pkg.sv
hdl/gbfs_mark_ram.sv
hdl/gbfs_queue_ram.sv
hdl/grid_breadth_first_search.sv
sim/tb_grid_breadth_first_search.sv
